// ===== rtl/serial_loaded_waveform_player_assert.svh =====
// Assertion macros for the serial-loaded waveform player.
// Used by the top level; depends on nothing else.
`ifndef SERIAL_LOADED_WAVEFORM_PLAYER_ASSERT_SVH
`define SERIAL_LOADED_WAVEFORM_PLAYER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SLWP_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define SLWP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slwp_pkg.sv =====
// Shared constants and types for the serial-loaded waveform player.
// No dependencies; imported by every module of the block.
`default_nettype none

package slwp_pkg;

  // Default table length
  localparam int NUM_VALUES_DEF = 64;

  // Line format
  localparam int CHARS_PER_RECORD = 5;
  localparam int DIGITS_PER_VALUE = 3;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] SEP_BYTE   = 8'h3B;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  // Field widths
  localparam int CV_W   = 10;
  localparam int CODE_W = 12;

  // Limit register reset value, centivolts
  localparam logic [CV_W-1:0] LIMIT_RESET = 10'd300;

  // Input kind (tuser) and result kind (tuser)
  localparam logic KIND_BYTE     = 1'b0;
  localparam logic KIND_TICK     = 1'b1;
  localparam logic RESULT_REPLY  = 1'b0;
  localparam logic RESULT_SAMPLE = 1'b1;

  // code = floor(cv * 4095 / 300) = floor(cv * 273 / 20)
  // /20 is a shift by two and a reciprocal multiply for /5 (exact below 2^18)
  localparam int SCALE_NUM   = 273;
  localparam int RECIP_FIVE  = 209716;
  localparam int RECIP_SHIFT = 20;
  localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_OVER_LIMIT = 2'd1,
    ST_BAD_FORMAT = 2'd2
  } reply_status_t;

  // Verdict of the line parser on the line ended by the current CR
  typedef struct packed {
    logic          accepted;
    reply_status_t status;
  } line_result_t;

endpackage

`default_nettype wire

// ===== rtl/slwp_bank_mem.sv =====
// Two-bank value memory: one write port, one read port, registered read data.
// Uses slwp_pkg for the data width.
`default_nettype none

module slwp_bank_mem #(
  parameter int DEPTH  = 2 * slwp_pkg::NUM_VALUES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [slwp_pkg::CV_W-1:0]   wdata,
  input  wire logic                        re,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [slwp_pkg::CV_W-1:0]   rdata
);
  import slwp_pkg::*;

  logic [CV_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slwp_line.sv =====
// Line parser: counts characters and digits, assembles values, writes them
// into the inactive bank and judges the line at CR. Uses slwp_pkg.
`default_nettype none

module slwp_line #(
  parameter int NUM_VALUES = slwp_pkg::NUM_VALUES_DEF,
  parameter int ADDR_W     = $clog2(2 * NUM_VALUES)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take_char,
  input  wire logic                       end_line,
  input  wire logic [7:0]                 rx_byte,
  input  wire logic [slwp_pkg::CV_W-1:0]  limit,
  input  wire logic                       active_bank,
  output logic                            mem_we,
  output logic      [ADDR_W-1:0]          mem_waddr,
  output logic      [slwp_pkg::CV_W-1:0]  mem_wdata,
  output slwp_pkg::line_result_t          result
);
  import slwp_pkg::*;

  localparam int LINE_LEN    = CHARS_PER_RECORD * NUM_VALUES;
  localparam int DIGIT_TOTAL = DIGITS_PER_VALUE * NUM_VALUES;
  localparam int CC_W        = $clog2(LINE_LEN + 2);
  localparam int DC_W        = $clog2(DIGIT_TOTAL + 2);
  localparam int IDX_W       = $clog2(NUM_VALUES);

  logic [CC_W-1:0]  char_count;
  logic [DC_W-1:0]  digit_count;
  logic [2:0]       sep_phase;
  logic [1:0]       digit_phase;
  logic [IDX_W-1:0] value_idx;
  logic [CV_W-1:0]  partial_value;
  logic             format_error;
  logic [CV_W-1:0]  largest_value;

  logic             pos_ok;
  logic             digits_room;
  logic             is_digit;
  logic [13:0]      value_wide;
  logic [CV_W-1:0]  value_sum;
  logic             last_digit;
  logic             bad_line;

  // Decode the character and build the next partial value
  always_comb begin
    pos_ok      = char_count < CC_W'(LINE_LEN);
    digits_room = digit_count < DC_W'(DIGIT_TOTAL);
    is_digit    = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
    value_wide  = 14'(partial_value) * 14'd10 + {10'd0, rx_byte[3:0]};
    value_sum   = value_wide[CV_W-1:0];
    last_digit  = digit_phase == 2'(DIGITS_PER_VALUE - 1);
  end

  // Store a finished value into the bank that is not playing
  always_comb begin
    mem_we    = take_char && pos_ok && is_digit && digits_room && last_digit;
    mem_waddr = ADDR_W'(value_idx) + (active_bank ? '0 : ADDR_W'(NUM_VALUES));
    mem_wdata = value_sum;
  end

  // Judge the line at CR
  always_comb begin
    bad_line = format_error || (char_count != CC_W'(LINE_LEN))
               || (digit_count != DC_W'(DIGIT_TOTAL));
    result.accepted = 1'b0;
    if (bad_line) begin
      result.status = ST_BAD_FORMAT;
    end else if (largest_value > limit) begin
      result.status = ST_OVER_LIMIT;
    end else begin
      result.status   = ST_ACCEPTED;
      result.accepted = 1'b1;
    end
  end

  // Advance the line counters; clear everything at CR
  always_ff @(posedge clk) begin
    if (rst || end_line) begin
      char_count    <= '0;
      digit_count   <= '0;
      sep_phase     <= '0;
      digit_phase   <= '0;
      value_idx     <= '0;
      partial_value <= '0;
      format_error  <= 1'b0;
      largest_value <= '0;
    end else if (take_char) begin
      if (!pos_ok) begin
        char_count   <= CC_W'(LINE_LEN + 1);
        format_error <= 1'b1;
      end else begin
        char_count <= char_count + 1'b1;
        if (sep_phase == 3'(CHARS_PER_RECORD - 1)) begin
          sep_phase <= '0;
          if (rx_byte != SEP_BYTE) begin
            format_error <= 1'b1;
          end
        end else begin
          sep_phase <= sep_phase + 1'b1;
        end
        if (is_digit) begin
          if (digits_room) begin
            digit_count <= digit_count + 1'b1;
            if (last_digit) begin
              digit_phase   <= '0;
              partial_value <= '0;
              value_idx     <= value_idx + 1'b1;
              if (value_sum > largest_value) begin
                largest_value <= value_sum;
              end
            end else begin
              digit_phase   <= digit_phase + 1'b1;
              partial_value <= value_sum;
            end
          end else begin
            digit_count <= DC_W'(DIGIT_TOTAL + 1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/slwp_scale.sv =====
// Two-stage centivolt to converter code scaler: cv*273, then /20 by shift
// and reciprocal multiply, saturated at full scale. Uses slwp_pkg.
`default_nettype none

module slwp_scale (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [slwp_pkg::CV_W-1:0]   cv,
  output logic      [slwp_pkg::CODE_W-1:0] code
);
  import slwp_pkg::*;

  logic [18:0] scaled;
  logic [16:0] quarter;
  logic [34:0] recip_prod;
  logic [14:0] quot;
  logic [CODE_W-1:0] code_next;

  // Stage one: cv * 273
  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= 19'(cv) * 19'(SCALE_NUM);
    end
  end

  // Stage two: divide by 4, then by 5, and saturate
  always_comb begin
    quarter    = scaled[18:2];
    recip_prod = 35'(quarter) * 35'(RECIP_FIVE);
    quot       = recip_prod[34:RECIP_SHIFT];
    code_next  = (quot > 15'(CODE_MAX)) ? CODE_MAX : quot[CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code <= code_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/serial_loaded_waveform_player.sv =====
// Serial-loaded waveform player, top level.
// Each result is registered through the memory read, the scale multiply and the reciprocal
// multiply; one input transaction per cycle while the pipeline is not stalled.
// The whole pipeline stalls only while the output register holds an untaken result.
// Reset (rst, synchronous): limit 300, bank 0, not playing, index 0, line cleared;
// the value memory is not cleared and needs no clearing pass.
`default_nettype none

module serial_loaded_waveform_player #(
  parameter int NUM_VALUES = slwp_pkg::NUM_VALUES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] req_type
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // [1:0] reply_status, [13:2] dac_code, [15:14] zero
  output logic             m_tuser,   // [0] result_kind
  // Limit register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [slwp_pkg::CV_W-1:0] cfg_data
);
  import slwp_pkg::*;

  localparam int DEPTH  = 2 * NUM_VALUES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(NUM_VALUES);

  logic [CV_W-1:0]   limit;
  logic              active_bank;
  logic              playing;
  logic [IDX_W-1:0]  play_index;

  logic              advance;
  logic              accept;
  logic              is_tick;
  logic              is_cr;
  logic              take_char;
  logic              end_line;
  logic              emit_tick;
  logic [ADDR_W-1:0] raddr;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CV_W-1:0]   mem_wdata;
  logic [CV_W-1:0]   mem_rdata;
  line_result_t      line_result;
  logic [CODE_W-1:0] code;

  logic              st1_valid, st2_valid, st3_valid;
  logic              st1_kind, st2_kind, st3_kind;
  reply_status_t     st1_status, st2_status, st3_status;

  // Handshake and transaction decode
  always_comb begin
    advance   = !st3_valid || m_tready;
    s_tready  = advance;
    accept    = s_tvalid && advance;
    is_tick   = s_tuser == KIND_TICK;
    is_cr     = s_tdata == CR_BYTE;
    take_char = accept && !is_tick && !is_cr;
    end_line  = accept && !is_tick && is_cr;
    emit_tick = accept && is_tick && playing;
    raddr     = ADDR_W'(play_index) + (active_bank ? ADDR_W'(NUM_VALUES) : '0);
  end

  // Limit register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // Swap banks on an accepted line, advance the play index on each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= 1'b0;
      playing     <= 1'b0;
      play_index  <= '0;
    end else begin
      if (end_line && line_result.accepted) begin
        active_bank <= !active_bank;
        playing     <= 1'b1;
      end
      if (emit_tick) begin
        play_index <= (play_index == IDX_W'(NUM_VALUES - 1)) ? '0 : play_index + 1'b1;
      end
    end
  end

  slwp_line #(
    .NUM_VALUES (NUM_VALUES),
    .ADDR_W     (ADDR_W)
  ) u_line (
    .clk         (clk),
    .rst         (rst),
    .take_char   (take_char),
    .end_line    (end_line),
    .rx_byte     (s_tdata),
    .limit       (limit),
    .active_bank (active_bank),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .result      (line_result)
  );

  // Writes go only to the idle bank and reads only to the playing one,
  // so a read never meets a write to the same entry
  slwp_bank_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (emit_tick),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  slwp_scale u_scale (
    .clk  (clk),
    .en   (advance),
    .cv   (mem_rdata),
    .code (code)
  );

  // Result pipeline: kind and status travel beside the sample data
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
    end else if (advance) begin
      st1_valid <= end_line || emit_tick;
      st2_valid <= st1_valid;
      st3_valid <= st2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st1_kind   <= is_tick ? RESULT_SAMPLE : RESULT_REPLY;
      st1_status <= is_tick ? ST_ACCEPTED : line_result.status;
      st2_kind   <= st1_kind;
      st2_status <= st1_status;
      st3_kind   <= st2_kind;
      st3_status <= st2_status;
    end
  end

  // Output register
  always_comb begin
    m_tvalid = st3_valid;
    m_tuser  = st3_kind;
    m_tdata  = {2'b00, (st3_kind == RESULT_SAMPLE) ? code : '0, st3_status};
  end

  `include "serial_loaded_waveform_player_assert.svh"

  `SLWP_ASSERT_NOW(a_reply_no_code, clk, rst, m_tvalid && (m_tuser == RESULT_REPLY), m_tdata[13:2] == '0, "line reply carries a converter code")
  `SLWP_ASSERT_NOW(a_write_idle_bank, clk, rst, mem_we, (mem_waddr >= ADDR_W'(NUM_VALUES)) != active_bank, "value write hits the playing bank")
  `SLWP_ASSERT_NEXT(a_playing_sticks, clk, rst, playing, playing, "playback stopped without reset")

endmodule

`default_nettype wire

// ===== test/serial_loaded_waveform_player_tb.sv =====
// Testbench for serial_loaded_waveform_player: text lines and sample ticks in, replies and
// converter codes out, checked against a behavioral copy of the line parser and player.
// Depends on slwp_pkg and the top level in rtl/.
`default_nettype none

module serial_loaded_waveform_player_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slwp_pkg::*;

  localparam int LINE_LEN      = CHARS_PER_RECORD * NUM_VALUES_DEF;
  localparam int DIGIT_TOTAL   = DIGITS_PER_VALUE * NUM_VALUES_DEF;
  localparam int SLOT_TOTAL    = LINE_LEN - NUM_VALUES_DEF;
  localparam int SEP_POS       = CHARS_PER_RECORD - 1;
  localparam int FILL_POS      = CHARS_PER_RECORD - 2;
  localparam int CV_FULL_SCALE = 300;
  localparam int CV_MAX        = 999;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 400;

  typedef struct packed {
    logic              kind;
    reply_status_t     status;
    logic [CODE_W-1:0] code;
  } player_out_t;

  typedef enum {ROW_TICK, ROW_LINE, ROW_LIMIT} row_op_t;
  typedef enum {
    LF_FLAT, LF_RAMP, LF_MIXED, LF_SHORT, LF_LONG, LF_BAD_SEP, LF_MANY_DIGITS, LF_FEW_DIGITS
  } line_form_t;
  // Where the transaction's result comes from: the player copy, nothing, or the table
  typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_t;

  typedef struct {
    row_op_t     op;
    line_form_t  form;
    int          arg;
    logic [7:0]  fill;
    int          count;
    row_check_t  chk;
    player_out_t want;
  } stim_row_t;

  localparam player_out_t NO_OUT = '0;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;   // [7:0] rx_byte
  logic             s_tuser;   // [0] req_type
  logic             m_tvalid;
  logic             m_tready;
  logic [15:0]      m_tdata;   // [1:0] reply_status, [13:2] dac_code, [15:14] zero
  logic             m_tuser;   // [0] result_kind
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CV_W-1:0]  cfg_data;

  serial_loaded_waveform_player #(.NUM_VALUES(NUM_VALUES_DEF)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Player copy: wave memory, line parser and playback position
  logic [CV_W-1:0] wave_mem [2*NUM_VALUES_DEF];
  logic            sel_bank;
  logic [8:0]      line_chars;
  logic [8:0]      line_digits;
  logic [CV_W-1:0] line_part;
  logic            line_bad;
  logic [CV_W-1:0] line_peak;
  logic [5:0]      tick_pos;
  logic            running;
  int              limit_cv;

  player_out_t outputs_due[$];
  stim_row_t   dir_rows[$];
  int          mismatches;
  int          cycle_count;
  int          items_sent;
  int          send_gap_pct;
  int          recv_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Compute the result of one input transaction and advance the player copy
  function automatic bit next_player_output(input logic kind, input logic [7:0] ch,
                                            output player_out_t res);
    int v;
    int pos;
    int idx;
    res = '0;
    if (kind == KIND_BYTE) begin
      if (ch == CR_BYTE) begin
        res.kind = RESULT_REPLY;
        if (line_bad || line_chars != LINE_LEN || line_digits != DIGIT_TOTAL) begin
          res.status = ST_BAD_FORMAT;
        end else if (line_peak > limit_cv) begin
          res.status = ST_OVER_LIMIT;
        end else begin
          res.status = ST_ACCEPTED;
          sel_bank = ~sel_bank;
          running = 1'b1;
        end
        line_chars = '0;
        line_digits = '0;
        line_part = '0;
        line_bad = 1'b0;
        line_peak = '0;
        return 1'b1;
      end
      // Saturate the length of an overlong line
      if (line_chars >= LINE_LEN) begin
        line_chars = 9'(LINE_LEN + 1);
        line_bad = 1'b1;
        return 1'b0;
      end
      pos = int'(line_chars);
      line_chars = line_chars + 9'd1;
      if (pos % CHARS_PER_RECORD == SEP_POS && ch != SEP_BYTE) line_bad = 1'b1;
      if (ch >= DIGIT_ZERO && ch <= DIGIT_NINE) begin
        if (line_digits < DIGIT_TOTAL) begin
          v = int'(line_part) * 10 + int'(ch - DIGIT_ZERO);
          if (int'(line_digits) % DIGITS_PER_VALUE == DIGITS_PER_VALUE - 1) begin
            idx = (sel_bank ? 0 : NUM_VALUES_DEF) + int'(line_digits) / DIGITS_PER_VALUE;
            wave_mem[idx] = v[CV_W-1:0];
            if (v > int'(line_peak)) line_peak = v[CV_W-1:0];
            line_part = '0;
          end else begin
            line_part = v[CV_W-1:0];
          end
          line_digits = line_digits + 9'd1;
        end else begin
          line_digits = 9'(DIGIT_TOTAL + 1);
        end
      end
      return 1'b0;
    end
    // Tick: play the active bank once a line has been taken
    if (!running) return 1'b0;
    idx = (sel_bank ? NUM_VALUES_DEF : 0) + int'(tick_pos);
    v = int'(wave_mem[idx]) * int'(CODE_MAX) / CV_FULL_SCALE;
    if (v > int'(CODE_MAX)) v = int'(CODE_MAX);
    res.kind = RESULT_SAMPLE;
    res.status = ST_ACCEPTED;
    res.code = v[CODE_W-1:0];
    tick_pos = tick_pos + 6'd1;
    return 1'b1;
  endfunction

  function automatic player_out_t reply_of(input reply_status_t st);
    player_out_t r;
    r = '0;
    r.kind = RESULT_REPLY;
    r.status = st;
    return r;
  endfunction

  function automatic player_out_t sample_of(input logic [CODE_W-1:0] code);
    player_out_t r;
    r = '0;
    r.kind = RESULT_SAMPLE;
    r.code = code;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= DIGIT_ZERO && c <= DIGIT_NINE;
  endfunction

  function automatic logic [7:0] digit_char(input int v, input int n);
    int d;
    d = (n == 0) ? v / 100 : (n == 1) ? (v / 10) % 10 : v % 10;
    return DIGIT_ZERO + 8'(d);
  endfunction

  // Any byte that is neither a digit nor a CR, with extra weight on ';'
  function automatic logic [7:0] rand_filler();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return SEP_BYTE;
    do c = 8'($urandom_range(0, 255)); while (is_digit(c) || c == CR_BYTE);
    return c;
  endfunction

  function automatic int pick_value(input int mode);
    if (mode != 2 && $urandom_range(0, 9) == 0) return limit_cv;
    if (mode == 2) return $urandom_range(0, CV_MAX);
    return $urandom_range(0, limit_cv);
  endfunction

  // Regular layout: three digits, one filler, then the separator, per record
  function automatic void flat_line(input int base, input int step, input logic [7:0] fill,
                                    ref logic [7:0] txt[$]);
    txt.delete();
    for (int r = 0; r < NUM_VALUES_DEF; r++) begin
      for (int n = 0; n < DIGITS_PER_VALUE; n++) txt.push_back(digit_char(base + r * step, n));
      txt.push_back(fill);
      txt.push_back(SEP_BYTE);
    end
  endfunction

  // Well-formed line with digits scattered over the non-separator slots
  function automatic void mixed_line(input int mode, ref logic [7:0] txt[$]);
    int vals[NUM_VALUES_DEF];
    bit slot_digit[SLOT_TOTAL];
    bit t;
    int j;
    int k;
    int d_idx;
    for (int i = 0; i < NUM_VALUES_DEF; i++) vals[i] = pick_value(mode);
    if (mode == 1 && limit_cv < CV_MAX) vals[$urandom_range(0, NUM_VALUES_DEF - 1)] = limit_cv + 1;
    for (int i = 0; i < SLOT_TOTAL; i++) slot_digit[i] = (i < DIGIT_TOTAL);
    for (int i = SLOT_TOTAL - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = slot_digit[i];
      slot_digit[i] = slot_digit[j];
      slot_digit[j] = t;
    end
    txt.delete();
    k = 0;
    d_idx = 0;
    for (int pos = 0; pos < LINE_LEN; pos++) begin
      if (pos % CHARS_PER_RECORD == SEP_POS) begin
        txt.push_back(SEP_BYTE);
      end else begin
        if (slot_digit[k]) begin
          txt.push_back(digit_char(vals[d_idx / DIGITS_PER_VALUE], d_idx % DIGITS_PER_VALUE));
          d_idx++;
        end else begin
          txt.push_back(rand_filler());
        end
        k++;
      end
    end
  endfunction

  function automatic void build_line(input line_form_t form, input int arg,
                                     input logic [7:0] fill, ref logic [7:0] txt[$]);
    case (form)
      LF_FLAT: flat_line(arg, 0, fill, txt);
      LF_RAMP: flat_line(0, 15, fill, txt);
      LF_MIXED: mixed_line(arg, txt);
      LF_SHORT: begin
        flat_line(0, 0, fill, txt);
        while (txt.size() > arg) void'(txt.pop_back());
      end
      LF_LONG: begin
        flat_line(123, 0, fill, txt);
        repeat (arg) txt.push_back(DIGIT_ZERO + 8'd5);
      end
      LF_BAD_SEP: begin
        flat_line(0, 0, 8'h20, txt);
        txt[arg] = fill;
      end
      LF_MANY_DIGITS: begin
        flat_line(arg, 0, 8'h20, txt);
        for (int r = 0; r < NUM_VALUES_DEF; r++)
          txt[r * CHARS_PER_RECORD + FILL_POS] = DIGIT_ZERO + 8'd7;
      end
      LF_FEW_DIGITS: begin
        flat_line(555, 0, 8'h20, txt);
        txt[0] = fill;
      end
      default: txt.delete();
    endcase
  endfunction

  // Offer one transaction after a random gap, and record its result once taken
  task automatic send_request(input logic kind, input logic [7:0] ch, input row_check_t chk,
                              input player_out_t want);
    player_out_t res;
    bit has;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= ch;
    do @(posedge clk); while (!s_tready);
    has = next_player_output(kind, ch, res);
    if (chk == CHK_TYPED) outputs_due.push_back(want);
    else if (chk == CHK_MODEL && has) outputs_due.push_back(res);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(ref logic [7:0] txt[$], input row_check_t chk,
                           input player_out_t want);
    foreach (txt[i]) send_request(KIND_BYTE, txt[i], CHK_MODEL, NO_OUT);
    send_request(KIND_BYTE, CR_BYTE, chk, want);
  endtask

  // Hold the input idle until every result has come out and the pipeline is empty
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= CV_W'(v);
    do @(posedge clk); while (!cfg_ready);
    limit_cv = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A random mix of well-formed lines with random content, broken lines, noise and ticks
  task automatic run_random(input int n_items);
    logic [7:0] txt[$];
    int start;
    int pick;
    int p;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        mixed_line($urandom_range(0, 2), txt);
        send_line(txt, CHK_MODEL, NO_OUT);
      end else if (pick < 55) begin
        mixed_line($urandom_range(0, 2), txt);
        case ($urandom_range(0, 4))
          0: begin
            p = $urandom_range(0, LINE_LEN - 1);
            while (txt.size() > p) void'(txt.pop_back());
          end
          1: repeat ($urandom_range(1, 8)) begin
            do txt.push_back(8'($urandom_range(0, 255))); while (txt[$] == CR_BYTE);
          end
          2: begin
            p = $urandom_range(0, NUM_VALUES_DEF - 1) * CHARS_PER_RECORD + SEP_POS;
            do txt[p] = 8'($urandom_range(0, 255)); while (txt[p] == SEP_BYTE || txt[p] == CR_BYTE);
          end
          3: begin
            do p = $urandom_range(0, LINE_LEN - 1);
            while (is_digit(txt[p]) || p % CHARS_PER_RECORD == SEP_POS);
            txt[p] = DIGIT_ZERO + 8'($urandom_range(0, 9));
          end
          default: begin
            do p = $urandom_range(0, LINE_LEN - 1); while (!is_digit(txt[p]));
            txt[p] = rand_filler();
          end
        endcase
        send_line(txt, CHK_MODEL, NO_OUT);
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 6))
          send_request(KIND_BYTE, 8'($urandom_range(0, 255)), CHK_MODEL, NO_OUT);
      end else begin
        repeat ($urandom_range(1, 24))
          send_request(KIND_TICK, 8'($urandom_range(0, 255)), CHK_MODEL, NO_OUT);
      end
    end
  endtask

  // Stall the output side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each output transaction with the oldest result due
  always @(posedge clk) begin
    player_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outputs_due.size() == 0) begin
        $display("%0t: result with none due: kind %0d tdata %h", $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = outputs_due.pop_front();
        if (m_tuser !== want.kind) begin
          $display("%0t: result_kind expected %0d, got %0d", $time, want.kind, m_tuser);
          mismatches++;
        end
        if (m_tdata[1:0] !== want.status) begin
          $display("%0t: reply_status expected %0d, got %0d", $time, want.status, m_tdata[1:0]);
          mismatches++;
        end
        if (m_tdata[13:2] !== want.code) begin
          $display("%0t: dac_code expected %0d, got %0d", $time, want.code, m_tdata[13:2]);
          mismatches++;
        end
        if (m_tdata[15:14] !== 2'b00) begin
          $display("%0t: tdata pad expected 0, got %b", $time, m_tdata[15:14]);
          mismatches++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] txt[$];
    stim_row_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_BYTE;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    items_sent = 0;
    send_gap_pct = 10;
    recv_stall_pct = 79;
    foreach (wave_mem[i]) wave_mem[i] = '0;
    sel_bank = 1'b0;
    line_chars = '0;
    line_digits = '0;
    line_part = '0;
    line_bad = 1'b0;
    line_peak = '0;
    tick_pos = '0;
    running = 1'b0;
    limit_cv = int'(LIMIT_RESET);

    dir_rows = '{
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 1,  CHK_NONE,  NO_OUT},
      '{ROW_LINE,  LF_SHORT,       0,   8'h20, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_FLAT,        300, 8'h00, 1,  CHK_TYPED, reply_of(ST_ACCEPTED)},
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 1,  CHK_TYPED, sample_of(12'd4095)},
      '{ROW_LINE,  LF_FLAT,        301, 8'hFF, 1,  CHK_TYPED, reply_of(ST_OVER_LIMIT)},
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 2,  CHK_TYPED, sample_of(12'd4095)},
      '{ROW_LINE,  LF_FLAT,        150, 8'h3B, 1,  CHK_TYPED, reply_of(ST_ACCEPTED)},
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 1,  CHK_TYPED, sample_of(12'd2047)},
      '{ROW_LINE,  LF_RAMP,        0,   8'h78, 1,  CHK_MODEL, NO_OUT},
      '{ROW_LIMIT, LF_FLAT,        999, 8'h00, 1,  CHK_MODEL, NO_OUT},
      '{ROW_LINE,  LF_FLAT,        999, 8'h80, 1,  CHK_TYPED, reply_of(ST_ACCEPTED)},
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 1,  CHK_TYPED, sample_of(12'd4095)},
      '{ROW_LINE,  LF_RAMP,        0,   8'h7F, 1,  CHK_MODEL, NO_OUT},
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 70, CHK_MODEL, NO_OUT},
      '{ROW_LINE,  LF_SHORT,       319, 8'h20, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_LONG,        1,   8'h20, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_LONG,        40,  8'h20, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_BAD_SEP,     4,   8'h61, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_BAD_SEP,     319, 8'h3A, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_MANY_DIGITS, 500, 8'h20, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_FEW_DIGITS,  0,   8'h20, 1,  CHK_TYPED, reply_of(ST_BAD_FORMAT)},
      '{ROW_LINE,  LF_MIXED,       2,   8'h00, 1,  CHK_MODEL, NO_OUT},
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 5,  CHK_MODEL, NO_OUT},
      '{ROW_LIMIT, LF_FLAT,        0,   8'h00, 1,  CHK_MODEL, NO_OUT},
      '{ROW_LINE,  LF_FLAT,        1,   8'h01, 1,  CHK_TYPED, reply_of(ST_OVER_LIMIT)},
      '{ROW_LINE,  LF_FLAT,        0,   8'hFE, 1,  CHK_TYPED, reply_of(ST_ACCEPTED)},
      '{ROW_TICK,  LF_FLAT,        0,   8'h00, 2,  CHK_TYPED, sample_of(12'd0)}
    };

    // Hold reset, then release it
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      case (r.op)
        ROW_LIMIT: write_limit(r.arg);
        ROW_TICK: repeat (r.count)
          send_request(KIND_TICK, 8'($urandom_range(0, 255)), r.chk, r.want);
        default: begin
          build_line(r.form, r.arg, r.fill, txt);
          send_line(txt, r.chk, r.want);
        end
      endcase
    end

    // Random phases: output stalls heavy, then input gaps heavy, then no idling
    write_limit(CV_MAX);
    run_random(PHASE_ITEMS);
    write_limit(0);
    send_gap_pct = 79;
    recv_stall_pct = 10;
    run_random(PHASE_ITEMS);
    write_limit($urandom_range(1, CV_MAX - 1));
    send_gap_pct = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);

    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
